[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define CHR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// An implication: the consequent must hold in the same cycle as the antecedent.
`define CHR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/chr_pkg.sv]
// ----------------------------------------------------------------------------
// chr_pkg
// Types, constants and hash helpers for the consistent hash ring core.
// ----------------------------------------------------------------------------
`default_nettype none

package chr_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int MAX_NODES   = 16;
	localparam int AW          = $clog2(MAX_ENTRIES);
	localparam int CW          = AW + 1;
	localparam int NVW         = 11;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [63:0] FNV_MUL_LO = 64'h0000_0000_0000_01B3;
	localparam logic [7:0]  CHAR_HASH = 8'h23;
	localparam logic [7:0]  CHAR_ZERO = 8'h30;
	localparam logic [4:0]  VN_RESET  = 5'd4;
	localparam logic [4:0]  WANT_MAX  = (MAX_NODES < 16) ? 5'(MAX_NODES) : 5'd16;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_LOOKUP   = 2'd2,
		OP_REPLICAS = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VH_HASH,
		ST_VH_TENS,
		ST_VH_ONES,
		ST_BS_RD,
		ST_BS_CMP,
		ST_EQ_RD,
		ST_EQ_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DN_RD,
		ST_DN_WR,
		ST_LK_CMP,
		ST_WK_RD,
		ST_WK_CMP
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] data_byte;
		logic       last_byte;
		logic [3:0] node_number;
		logic [4:0] replica_count;
	} cmd_t;

	typedef struct packed {
		logic [3:0] owner;
		logic       found;
		logic       table_full;
		logic       last_result;
	} result_t;

	typedef struct packed {
		logic [63:0] position;
		logic [3:0]  owner;
	} entry_t;

	// One FNV-1a step. The prime is 2^40 + 0x1B3, so the product is a shift
	// plus a narrow multiply.
	function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x * FNV_MUL_LO);
	endfunction

	function automatic logic [1:0] tens_digit(input logic [4:0] idx);
		logic [1:0] t;
		if (idx >= 5'd30) t = 2'd3;
		else if (idx >= 5'd20) t = 2'd2;
		else if (idx >= 5'd10) t = 2'd1;
		else t = 2'd0;
		return t;
	endfunction

	function automatic logic [7:0] tens_char(input logic [4:0] idx);
		return CHAR_ZERO + {6'd0, tens_digit(idx)};
	endfunction

	function automatic logic [7:0] ones_char(input logic [4:0] idx);
		logic [4:0] r;
		r = idx - (5'(tens_digit(idx)) * 5'd10);
		return CHAR_ZERO + {3'd0, r};
	endfunction

endpackage

`default_nettype wire

[rtl/consistent_hash_ring_core.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_core
// Sorted ring of 64-bit FNV-1a positions with node owners, served by one
// sequencer around a single ring memory and one shared hash unit.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                     | Handshake
//  ---------+-----------------------------+-----------------------------------
//  command  | start, busy, cmd            | beat taken when start && !busy
//  result   | result_valid, result        | one-cycle strobe, cannot stall
//  config   | cfg_we, cfg_data            | written when cfg_we is high
//
// A byte that is not the last one is folded into the running hash in the
// cycle it is taken, so name and key bytes stream at one beat per cycle
// while busy is low. On the last byte the sequencer runs and busy stays high.
// Every memory access sets the address, then uses the registered data: a
// binary search runs a read and a compare state per probe, and an add moves
// each entry above the insert point by a read and a write state, as a remove
// does for each entry above the erased one. A virtual node folds '#', a tens
// digit from index ten on and the ones digit into the name hash; replicas
// walk the ring by a read and a compare per visited entry. A lookup or
// replicas on an empty ring answers in the next cycle without raising busy.
// Reset clears the entry count and control state; the ring memory is not
// cleared, since only entries below the count are ever used. The receiver
// cannot stall, so each result beat is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire chr_pkg::cmd_t   cmd,
	input  wire logic            cfg_we,
	input  wire logic [4:0]      cfg_data,
	output logic                 result_valid,
	output chr_pkg::result_t     result
);
	import chr_pkg::*;

	`include "assert_macros.svh"

	state_t state_q, state_d;

	// Ring store: one write port, one registered read port.
	entry_t mem [MAX_ENTRIES];
	entry_t rd_q;
	logic [AW-1:0] rd_addr, wr_addr;
	logic          wr_en;
	entry_t        wr_data;

	logic [63:0]   running_q, name_q, vh_q;
	logic [4:0]    vn_q, vn_eff, vidx_q;
	logic [CW-1:0] count_q, lo_q, hi_q, ptr_q, wi_q, steps_q;
	logic [1:0]    op_q;
	logic [3:0]    node_q, pend_q;
	logic          pend_v_q, full_q;
	logic [4:0]    want_q, n_q;
	logic [NVW-1:0] nv_q;
	logic [15:0]   seen_q;

	logic          accept, acc_last;
	logic [63:0]   fold_h, fold_out;
	logic [7:0]    fold_b;
	logic [CW:0]   mid_sum;
	logic [CW-1:0] mid, wrap_lo, wi_nxt;
	logic          search_go, pos_less, eq, vn_last, walk_go, lo_in, drop_now;
	logic          emit;
	result_t       emit_data;
	logic [63:0]   key_hash;
	logic          in_search;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign acc_last = accept && cmd.last_byte;
	assign vn_eff   = (vn_q == 5'd0) ? 5'd1 : vn_q;

	// Shared hash unit: the running hash while idle, vnode suffixes otherwise.
	always_comb begin
		fold_h = vh_q;
		fold_b = ones_char(vidx_q);
		unique case (state_q)
			ST_IDLE: begin
				fold_h = running_q;
				fold_b = cmd.data_byte;
			end
			ST_VH_HASH: begin
				fold_h = name_q;
				fold_b = CHAR_HASH;
			end
			ST_VH_TENS: fold_b = tens_char(vidx_q);
			default: ;
		endcase
	end
	assign fold_out = fnv_fold(fold_h, fold_b);
	assign key_hash = fold_out;

	assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid       = mid_sum[CW:1];
	assign search_go = (lo_q < hi_q);
	assign pos_less  = (rd_q.position < vh_q);
	assign eq        = (rd_q.position == vh_q);
	assign lo_in     = (lo_q < count_q);
	assign wrap_lo   = lo_in ? lo_q : '0;
	assign vn_last   = ({1'b0, vidx_q} + 6'd1) >= {1'b0, vn_eff};
	assign walk_go   = (n_q < want_q) && (nv_q <= NVW'(count_q)) && (steps_q < count_q);
	assign wi_nxt    = ((wi_q + CW'(1)) >= count_q) ? '0 : (wi_q + CW'(1));
	assign drop_now  = (count_q >= CW'(MAX_ENTRIES));
	assign in_search = busy && (state_q == ST_BS_RD || state_q == ST_BS_CMP);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc_last) begin
					if (cmd.operation == OP_ADD || cmd.operation == OP_REMOVE) begin
						state_d = ST_VH_HASH;
					end else if (count_q != '0) begin
						state_d = ST_BS_RD;
					end
				end
			end
			ST_VH_HASH: state_d = (vidx_q >= 5'd10) ? ST_VH_TENS : ST_VH_ONES;
			ST_VH_TENS: state_d = ST_VH_ONES;
			ST_VH_ONES: state_d = ST_BS_RD;
			ST_BS_RD: begin
				if (search_go) begin
					state_d = ST_BS_CMP;
				end else begin
					unique case (op_q)
						OP_LOOKUP:   state_d = ST_LK_CMP;
						OP_REPLICAS: state_d = ST_WK_RD;
						default:     state_d = ST_EQ_RD;
					endcase
				end
			end
			ST_BS_CMP: state_d = ST_BS_RD;
			ST_EQ_RD: begin
				if (lo_in) begin
					state_d = ST_EQ_CMP;
				end else if (op_q == OP_ADD && !drop_now) begin
					state_d = ST_SH_RD;
				end else begin
					state_d = vn_last ? ST_IDLE : ST_VH_HASH;
				end
			end
			ST_EQ_CMP: begin
				if (op_q == OP_ADD && !eq && !drop_now) begin
					state_d = ST_SH_RD;
				end else if (op_q == OP_REMOVE && eq) begin
					state_d = ST_DN_RD;
				end else begin
					state_d = vn_last ? ST_IDLE : ST_VH_HASH;
				end
			end
			ST_SH_RD: begin
				if (ptr_q > lo_q) begin
					state_d = ST_SH_WR;
				end else begin
					state_d = vn_last ? ST_IDLE : ST_VH_HASH;
				end
			end
			ST_SH_WR: state_d = ST_SH_RD;
			ST_DN_RD: begin
				if ((ptr_q + CW'(1)) < count_q) begin
					state_d = ST_DN_WR;
				end else begin
					state_d = vn_last ? ST_IDLE : ST_VH_HASH;
				end
			end
			ST_DN_WR:  state_d = ST_DN_RD;
			ST_LK_CMP: state_d = ST_IDLE;
			ST_WK_RD:  state_d = walk_go ? ST_WK_CMP : ST_IDLE;
			ST_WK_CMP: state_d = ST_WK_RD;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Memory control and result beats.
	always_comb begin
		rd_addr   = mid[AW-1:0];
		wr_en     = 1'b0;
		wr_addr   = lo_q[AW-1:0];
		wr_data   = '{position: vh_q, owner: node_q};
		emit      = 1'b0;
		emit_data = '{owner: 4'd0, found: 1'b0, table_full: 1'b0, last_result: 1'b1};
		unique case (state_q)
			ST_IDLE: begin
				if (acc_last && count_q == '0 &&
				    (cmd.operation == OP_LOOKUP || cmd.operation == OP_REPLICAS)) begin
					emit = 1'b1;
				end
			end
			ST_BS_RD: begin
				if (!search_go) begin
					rd_addr = (op_q == OP_LOOKUP) ? wrap_lo[AW-1:0] : lo_q[AW-1:0];
				end
			end
			ST_EQ_RD: begin
				rd_addr = lo_q[AW-1:0];
				if (!lo_in && !(op_q == OP_ADD && !drop_now) && vn_last) begin
					emit = 1'b1;
					emit_data.table_full = (op_q == OP_ADD) && (full_q || drop_now);
				end
			end
			ST_EQ_CMP: begin
				if (op_q == OP_ADD && eq) begin
					wr_en = 1'b1;
				end
				if (!(op_q == OP_ADD && !eq && !drop_now) && !(op_q == OP_REMOVE && eq) &&
				    vn_last) begin
					emit = 1'b1;
					emit_data.table_full = (op_q == OP_ADD) && (full_q || (!eq && drop_now));
				end
			end
			ST_SH_RD: begin
				rd_addr = ptr_q[AW-1:0] - AW'(1);
				if (!(ptr_q > lo_q)) begin
					wr_en = 1'b1;
					if (vn_last) begin
						emit = 1'b1;
						emit_data.table_full = full_q;
					end
				end
			end
			ST_SH_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				wr_data = rd_q;
			end
			ST_DN_RD: begin
				rd_addr = ptr_q[AW-1:0] + AW'(1);
				if (!((ptr_q + CW'(1)) < count_q) && vn_last) begin
					emit = 1'b1;
				end
			end
			ST_DN_WR: begin
				wr_en   = 1'b1;
				wr_addr = ptr_q[AW-1:0];
				wr_data = rd_q;
			end
			ST_LK_CMP: begin
				emit = 1'b1;
				emit_data.owner = rd_q.owner;
				emit_data.found = 1'b1;
			end
			ST_WK_RD: begin
				rd_addr = wi_q[AW-1:0];
				if (!walk_go) begin
					emit = 1'b1;
					emit_data.owner = pend_v_q ? pend_q : 4'd0;
					emit_data.found = pend_v_q;
				end
			end
			ST_WK_CMP: begin
				if (!seen_q[rd_q.owner] && pend_v_q) begin
					emit = 1'b1;
					emit_data.owner       = pend_q;
					emit_data.found       = 1'b1;
					emit_data.last_result = 1'b0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			running_q    <= FNV_BASIS;
			count_q      <= '0;
			vn_q         <= VN_RESET;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			result_valid <= emit;
			if (cfg_we) begin
				vn_q <= cfg_data;
			end
			if (accept) begin
				running_q <= cmd.last_byte ? FNV_BASIS : fold_out;
			end
			if ((state_q == ST_SH_RD) && !(ptr_q > lo_q)) begin
				count_q <= count_q + CW'(1);
			end
			if ((state_q == ST_DN_RD) && !((ptr_q + CW'(1)) < count_q)) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (emit) begin
			result <= emit_data;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (acc_last) begin
					op_q     <= cmd.operation;
					node_q   <= cmd.node_number;
					name_q   <= key_hash;
					vh_q     <= key_hash;
					vidx_q   <= 5'd0;
					full_q   <= 1'b0;
					lo_q     <= '0;
					hi_q     <= count_q;
					want_q   <= (cmd.replica_count > WANT_MAX) ? WANT_MAX : cmd.replica_count;
					n_q      <= 5'd0;
					nv_q     <= NVW'(vn_eff);
					steps_q  <= '0;
					seen_q   <= '0;
					pend_v_q <= 1'b0;
				end
			end
			ST_VH_HASH, ST_VH_TENS: vh_q <= fold_out;
			ST_VH_ONES: begin
				vh_q <= fold_out;
				lo_q <= '0;
				hi_q <= count_q;
			end
			ST_BS_RD: begin
				if (!search_go) begin
					wi_q <= wrap_lo;
				end
			end
			ST_BS_CMP: begin
				if (pos_less) begin
					lo_q <= mid + CW'(1);
				end else begin
					hi_q <= mid;
				end
			end
			ST_EQ_RD: begin
				if (!lo_in) begin
					if (op_q == OP_ADD && !drop_now) begin
						ptr_q <= count_q;
					end else begin
						full_q <= full_q || (op_q == OP_ADD);
						vidx_q <= vidx_q + 5'd1;
					end
				end
			end
			ST_EQ_CMP: begin
				if (op_q == OP_ADD && !eq && !drop_now) begin
					ptr_q <= count_q;
				end else if (op_q == OP_REMOVE && eq) begin
					ptr_q <= lo_q;
				end else begin
					full_q <= full_q || (op_q == OP_ADD && !eq);
					vidx_q <= vidx_q + 5'd1;
				end
			end
			ST_SH_RD: begin
				if (!(ptr_q > lo_q)) begin
					vidx_q <= vidx_q + 5'd1;
				end
			end
			ST_SH_WR: ptr_q <= ptr_q - CW'(1);
			ST_DN_RD: begin
				if (!((ptr_q + CW'(1)) < count_q)) begin
					vidx_q <= vidx_q + 5'd1;
				end
			end
			ST_DN_WR: ptr_q <= ptr_q + CW'(1);
			ST_WK_CMP: begin
				if (!seen_q[rd_q.owner]) begin
					seen_q[rd_q.owner] <= 1'b1;
					pend_q   <= rd_q.owner;
					pend_v_q <= 1'b1;
					n_q      <= n_q + 5'd1;
					nv_q     <= nv_q + NVW'(vn_eff);
				end
				wi_q    <= wi_nxt;
				steps_q <= steps_q + CW'(1);
			end
			default: ;
		endcase
	end

	`CHR_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "entry count above capacity")
	`CHR_ASSERT_IMP(a_end_beat, $fell(busy), result_valid && result.last_result, "no final beat")
	`CHR_ASSERT_IMP(a_search_order, in_search, lo_q <= hi_q, "search bounds crossed")
	`CHR_ASSERT_IMP(a_none_owner, result_valid && !result.found, result.owner == 4'd0, "stray owner")

endmodule

`default_nettype wire

[tb/sv/consistent_hash_ring_checker.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_checker
// Watches the command, result and config channels of the hash ring core,
// keeps its own copy of the ring to predict every result beat, and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_checker
	import chr_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire logic    busy,
	input  wire cmd_t    cmd,
	input  wire logic    cfg_we,
	input  wire logic [4:0] cfg_data,
	input  wire logic    result_valid,
	input  wire result_t result,
	output int           pending,
	output int           failures
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] PRIME = 64'd1099511628211;

	logic [63:0] key_hash;
	logic [63:0] ring_pos [MAX_ENTRIES];
	logic [3:0]  ring_own [MAX_ENTRIES];
	int          ring_count;
	logic [4:0]  vnodes;
	result_t     owed_results [$];
	int          mismatch_count;

	assign failures = mismatch_count;

	function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
		return (h ^ {56'd0, b}) * PRIME;
	endfunction

	function automatic logic [63:0] vnode_position(input logic [63:0] h, input int idx);
		logic [63:0] p;
		p = hash_byte(h, CHAR_HASH);
		if (idx >= 10)
			p = hash_byte(p, CHAR_ZERO + 8'((idx / 10) % 10));
		return hash_byte(p, CHAR_ZERO + 8'(idx % 10));
	endfunction

	function automatic int first_at_or_above(input logic [63:0] h);
		int lo, hi, mid;
		lo = 0;
		hi = ring_count;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (ring_pos[mid] < h) lo = mid + 1;
			else hi = mid;
		end
		return lo;
	endfunction

	// Returns 0 when the position had to be dropped for lack of room.
	function automatic bit place_position(input logic [63:0] h, input logic [3:0] node);
		int i;
		i = first_at_or_above(h);
		if (i < ring_count && ring_pos[i] == h) begin
			ring_own[i] = node;
			return 1;
		end
		if (ring_count >= MAX_ENTRIES)
			return 0;
		for (int j = ring_count; j > i; j--) begin
			ring_pos[j] = ring_pos[j-1];
			ring_own[j] = ring_own[j-1];
		end
		ring_pos[i] = h;
		ring_own[i] = node;
		ring_count++;
		return 1;
	endfunction

	function automatic void drop_position(input logic [63:0] h);
		int i;
		i = first_at_or_above(h);
		if (i >= ring_count || ring_pos[i] != h)
			return;
		for (int j = i; j < ring_count - 1; j++) begin
			ring_pos[j] = ring_pos[j+1];
			ring_own[j] = ring_own[j+1];
		end
		ring_count--;
	endfunction

	function automatic result_t beat_of(input logic [3:0] o, input logic f, input logic t,
			input logic l);
		result_t r;
		r.owner = o;
		r.found = f;
		r.table_full = t;
		r.last_result = l;
		return r;
	endfunction

	// Appends one expected beat at the tail of the queue.
	function automatic void owe_beat(input result_t r);
		owed_results = {owed_results, r};
	endfunction

	task automatic predict_beat(input cmd_t c);
		logic [63:0] h;
		int vn, i, want, limit, steps, n;
		bit full;
		bit seen [16];
		h = hash_byte(key_hash, c.data_byte);
		key_hash = h;
		if (!c.last_byte)
			return;
		key_hash = FNV_BASIS;
		vn = (vnodes == 0) ? 1 : int'(vnodes);
		if (c.operation == OP_ADD) begin
			full = 0;
			for (int k = 0; k < vn; k++)
				if (!place_position(vnode_position(h, k), c.node_number))
					full = 1;
			owe_beat(beat_of(4'd0, 1'b0, full, 1'b1));
		end else if (c.operation == OP_REMOVE) begin
			for (int k = 0; k < vn; k++)
				drop_position(vnode_position(h, k));
			owe_beat(beat_of(4'd0, 1'b0, 1'b0, 1'b1));
		end else if (ring_count == 0) begin
			owe_beat(beat_of(4'd0, 1'b0, 1'b0, 1'b1));
		end else begin
			i = first_at_or_above(h);
			if (i >= ring_count) i = 0;
			if (c.operation == OP_LOOKUP) begin
				owe_beat(beat_of(ring_own[i], 1'b1, 1'b0, 1'b1));
			end else begin
				want = c.replica_count;
				if (want > 16) want = 16;
				if (want > MAX_NODES) want = MAX_NODES;
				limit = ring_count / vn;
				steps = 0;
				n = 0;
				foreach (seen[k]) seen[k] = 0;
				while (n < want && n < limit && steps < ring_count) begin
					if (!seen[ring_own[i]]) begin
						seen[ring_own[i]] = 1;
						owe_beat(beat_of(ring_own[i], 1'b1, 1'b0, 1'b0));
						n++;
					end
					i++;
					if (i >= ring_count) i = 0;
					steps++;
				end
				if (n == 0)
					owe_beat(beat_of(4'd0, 1'b0, 1'b0, 1'b1));
				else
					owed_results[owed_results.size() - 1].last_result = 1'b1;
			end
		end
	endtask

	task automatic report_mismatch(input string what, input result_t got, input result_t want);
		$write("%0t mismatch %s: got owner=%0d found=%0b full=%0b last=%0b, ",
			$realtime, what, got.owner, got.found, got.table_full, got.last_result);
		$display("want owner=%0d found=%0b full=%0b last=%0b",
			want.owner, want.found, want.table_full, want.last_result);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			key_hash = FNV_BASIS;
			ring_count = 0;
			vnodes = VN_RESET;
			owed_results.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we)
				vnodes = cfg_data;
			if (start && !busy)
				predict_beat(cmd);
			if (result_valid) begin
				if (owed_results.size() == 0) begin
					report_mismatch("unexpected beat", result, '0);
				end else begin
					want = owed_results.pop_front();
					if (result.owner !== want.owner)
						report_mismatch("owner", result, want);
					if (result.found !== want.found)
						report_mismatch("found", result, want);
					if (result.table_full !== want.table_full)
						report_mismatch("table_full", result, want);
					if (result.last_result !== want.last_result)
						report_mismatch("last_result", result, want);
				end
			end
		end
		pending = owed_results.size();
	end

endmodule

`default_nettype wire

[tb/sv/consistent_hash_ring_core_test.sv]
// ----------------------------------------------------------------------------
// consistent_hash_ring_core_test
// Streams name and key bytes into the hash ring core across several virtual
// node settings, with random sender gaps; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module consistent_hash_ring_core_test;
	import chr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// A single add with the widest virtual node setting can shift the full
	// ring once per position, so a long quiet stretch is legal.
	localparam int QUIET_LIMIT = 200000;
	localparam int POOL = 24;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	cmd_t    cmd = '0;
	logic    cfg_we = 1'b0;
	logic [4:0] cfg_data = '0;
	logic    result_valid;
	result_t result;
	int      pending;
	int      failures;
	int      quiet_cycles = 0;
	int      beats_sent = 0;

	// Name pool for adds and removes, so that removes usually hit.
	logic [7:0] pool_bytes [POOL][4];
	int         pool_len [POOL];
	logic [7:0] seq_bytes [$];

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	consistent_hash_ring_core DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
	);

	consistent_hash_ring_checker checker_i (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .result_valid(result_valid), .result(result),
		.pending(pending), .failures(failures)
	);

	// The watchdog only counts cycles in which no beat moves on either channel.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** consistent_hash_ring_core: FAILED **");
				$finish;
			end
		end
	end

	// Holds one command beat until the core takes it. Busy is looked at on the
	// falling edge, where it is stable, so the decision does not race the core.
	task automatic push_beat(input cmd_t c);
		bit taken;
		start <= 1'b1;
		cmd <= c;
		do begin
			@(negedge clk);
			taken = !busy;
			@(posedge clk);
		end while (!taken);
		beats_sent++;
	endtask

	// Waits until every predicted beat has come back and the core is idle, then
	// lets the sequencer's tail run out before anything else is changed.
	task automatic drain_ring;
		start <= 1'b0;
		do @(negedge clk); while (pending != 0 || busy);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_vnodes(input logic [4:0] v);
		drain_ring();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 5'($urandom);
		@(posedge clk);
	endtask

	// Sends the bytes in seq_bytes as one operation. Non-final beats carry
	// random operation, node and count fields, since only the last one acts.
	task automatic send_sequence(input logic [1:0] op, input logic [3:0] node,
			input logic [4:0] want, input int idle_pct);
		cmd_t c;
		for (int k = 0; k < seq_bytes.size(); k++) begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			c = cmd_t'($urandom);
			c.data_byte = seq_bytes[k];
			c.last_byte = (k == seq_bytes.size() - 1);
			if (c.last_byte) begin
				c.operation = op;
				c.node_number = node;
				c.replica_count = want;
			end
			push_beat(c);
		end
	endtask

	task automatic load_name(input int idx);
		seq_bytes.delete();
		for (int k = 0; k < pool_len[idx]; k++)
			seq_bytes = {seq_bytes, pool_bytes[idx][k]};
	endtask

	task automatic load_random_key(input int len);
		seq_bytes.delete();
		repeat (len) seq_bytes = {seq_bytes, 8'($urandom)};
	endtask

	task automatic random_phase(input int beats, input int idle_pct, input bit hold_once);
		int stop_at;
		int pick;
		logic [1:0] op;
		stop_at = beats_sent + beats;
		while (beats_sent < stop_at) begin
			if (hold_once && beats_sent > stop_at - beats / 2) begin
				hold_once = 0;
				drain_ring();
			end
			pick = $urandom_range(99);
			op = (pick < 35) ? OP_ADD : (pick < 50) ? OP_REMOVE : (pick < 72) ? OP_LOOKUP
				: OP_REPLICAS;
			// Adds and removes mostly use pool names, now and then a stray name as noise.
			if ((op == OP_ADD || op == OP_REMOVE) && $urandom_range(9) != 0)
				load_name($urandom_range(POOL - 1));
			else
				load_random_key($urandom_range(1, 4));
			send_sequence(op, 4'($urandom), 5'($urandom_range(0, 31)), idle_pct);
		end
	endtask

	initial begin
		foreach (pool_len[i]) begin
			pool_len[i] = $urandom_range(1, 4);
			for (int k = 0; k < 4; k++) pool_bytes[i][k] = 8'($urandom);
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring: lookup and replicas both answer with found low.
		seq_bytes = '{8'h00};
		send_sequence(OP_LOOKUP, 4'd3, 5'd5, 0);
		seq_bytes = '{8'hFF};
		send_sequence(OP_REPLICAS, 4'd3, 5'd4, 0);

		// Two nodes at the owner extremes, then the first name again with a new
		// owner, which overwrites its positions instead of adding.
		load_name(0);
		send_sequence(OP_ADD, 4'd0, 5'd0, 0);
		load_name(1);
		send_sequence(OP_ADD, 4'd15, 5'd0, 0);
		load_name(0);
		send_sequence(OP_ADD, 4'd7, 5'd0, 0);

		seq_bytes = '{8'h00, 8'hFF};
		send_sequence(OP_LOOKUP, 4'd0, 5'd0, 0);
		seq_bytes = '{8'hFF, 8'h00};
		send_sequence(OP_REPLICAS, 4'd0, 5'd31, 0);
		seq_bytes = '{8'h41};
		send_sequence(OP_REPLICAS, 4'd0, 5'd16, 0);
		send_sequence(OP_REPLICAS, 4'd0, 5'd0, 0);
		send_sequence(OP_REPLICAS, 4'd0, 5'd1, 0);

		// A remove of a name that was never added leaves the ring alone.
		seq_bytes = '{8'hAA, 8'h55, 8'hAA};
		send_sequence(OP_REMOVE, 4'd9, 5'd0, 0);
		load_name(1);
		send_sequence(OP_REMOVE, 4'd15, 5'd0, 0);
		seq_bytes = '{8'h41};
		send_sequence(OP_LOOKUP, 4'd0, 5'd0, 0);

		// Fill the store past its size with sixteen positions per name, so adds
		// near the end drop positions, then take those names out again.
		write_vnodes(5'd16);
		for (int n = 0; n < 18; n++) begin
			seq_bytes = '{8'hC0, 8'(n), 8'h5A};
			send_sequence(OP_ADD, 4'(n), 5'd0, 0);
		end
		seq_bytes = '{8'h12, 8'h34};
		send_sequence(OP_REPLICAS, 4'd0, 5'd16, 0);
		for (int n = 0; n < 18; n++) begin
			seq_bytes = '{8'hC0, 8'(n), 8'h5A};
			send_sequence(OP_REMOVE, 4'd0, 5'd0, 0);
		end

		// Zero virtual nodes behaves as one; the sender idles often here.
		write_vnodes(5'd0);
		random_phase(96, 27, 1'b1);

		// The widest setting, above the nominal range, with a slow sender.
		write_vnodes(5'd31);
		random_phase(56, 58, 1'b0);

		write_vnodes(5'd1);
		random_phase(50, 58, 1'b0);

		// No sender idling at all.
		write_vnodes(5'd7);
		random_phase(86, 0, 1'b0);

		drain_ring();
		if (failures == 0 && pending == 0) begin
			$display("** consistent_hash_ring_core: PASSED **");
		end else begin
			$display("** consistent_hash_ring_core: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
